[rtl/core/assert_macros.svh]
// Assertion macros used by the decoder core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_SYNC(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("%m: assertion failed");
`define ASSERT_NEVER(label, clk, rstn, cond) \
    `ASSERT_SYNC(label, clk, rstn, !(cond))
`else
`define ASSERT_SYNC(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, cond)
`endif
`endif

[rtl/core/asd_pkg.sv]
// Shared types, codes and tables of the audio sample stream decoder.
package asd_pkg;

    localparam logic [1:0] REG_CODEC_MODE       = 2'd0;
    localparam logic [1:0] REG_SAMPLE_COUNT     = 2'd1;
    localparam logic [1:0] REG_START_PREDICTOR  = 2'd2;
    localparam logic [1:0] REG_START_STEP_INDEX = 2'd3;

    localparam logic [1:0] MODE_S16LE = 2'd0;
    localparam logic [1:0] MODE_U8    = 2'd1;
    localparam logic [1:0] MODE_MULAW = 2'd2;
    localparam logic [1:0] MODE_ADPCM = 2'd3;

    localparam logic [6:0]  MAX_STEP_INDEX = 7'd88;
    localparam logic [31:0] SAMPLE_COUNT_RESET = 32'd1;
    localparam logic [9:0]  MULAW_BIAS = 10'h084;

    localparam logic [14:0] STEP_TABLE [0:88] = '{
        15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
        15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
        15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
        15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
        15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
        15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
        15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
        15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
        15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
        15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
        15'd27086, 15'd29794, 15'd32767
    };

    typedef struct packed {
        logic [1:0]         codec_mode;
        logic [31:0]        sample_count;
        logic signed [15:0] start_predictor;
        logic [6:0]         start_step_index;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last_of_run;
        logic               stream_done;
    } result_t;

    function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
        logic signed [4:0] adj;
        case (mag)
            3'd4:    adj = 5'sd2;
            3'd5:    adj = 5'sd4;
            3'd6:    adj = 5'sd6;
            3'd7:    adj = 5'sd8;
            default: adj = -5'sd1;
        endcase
        return adj;
    endfunction

    function automatic logic signed [15:0] mulaw_expand(input logic [7:0] code);
        logic [7:0]         inv;
        logic [16:0]        mag;
        logic signed [17:0] val;
        inv = ~code;
        mag = 17'({inv[3:0], 3'b000} + MULAW_BIAS) << inv[6:4];
        if (inv[7]) begin
            val = $signed({8'd0, MULAW_BIAS}) - $signed({1'b0, mag});
        end else begin
            val = $signed({1'b0, mag}) - $signed({8'd0, MULAW_BIAS});
        end
        return val[15:0];
    endfunction

endpackage

[rtl/core/asd_adpcm_unit.sv]
// One IMA ADPCM nibble update: predictor and step index with saturation.
module asd_adpcm_unit (
    input  logic signed [15:0] predictor,
    input  logic [6:0]         step_index,
    input  logic [3:0]         nibble,
    output logic signed [15:0] predictor_out,
    output logic [6:0]         step_index_out
);

    logic [6:0]         idx;
    logic [14:0]        step;
    logic [16:0]        diff;
    logic signed [17:0] sum;
    logic signed [7:0]  ni;

    always_comb begin
        idx  = (step_index > asd_pkg::MAX_STEP_INDEX) ? asd_pkg::MAX_STEP_INDEX : step_index;
        step = asd_pkg::STEP_TABLE[idx];
        diff = 17'(step >> 3);
        if (nibble[0]) diff = diff + 17'(step >> 2);
        if (nibble[1]) diff = diff + 17'(step >> 1);
        if (nibble[2]) diff = diff + 17'(step);
        if (nibble[3]) begin
            sum = 18'(predictor) - $signed({1'b0, diff});
        end else begin
            sum = 18'(predictor) + $signed({1'b0, diff});
        end
        if (sum > 18'sd32767) begin
            predictor_out = 16'sh7fff;
        end else if (sum < -18'sd32768) begin
            predictor_out = 16'sh8000;
        end else begin
            predictor_out = sum[15:0];
        end
        ni = $signed({1'b0, idx}) + 8'(asd_pkg::index_adjust(nibble[2:0]));
        if (ni < 8'sd0) begin
            step_index_out = 7'd0;
        end else if (ni > $signed({1'b0, asd_pkg::MAX_STEP_INDEX})) begin
            step_index_out = asd_pkg::MAX_STEP_INDEX;
        end else begin
            step_index_out = ni[6:0];
        end
    end

endmodule

[rtl/core/asd_decode_core.sv]
// Decoder state and per-cycle sample sequencing for all four codecs.
`include "assert_macros.svh"
module asd_decode_core (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  asd_pkg::cfg_t           cfg,
    input  logic                    item_valid,
    input  logic [7:0]              item_byte,
    input  logic                    item_first,
    input  logic                    out_ready,
    output logic                    consume,
    output logic                    emit,
    output asd_pkg::result_t        result
);

    logic signed [15:0] predictor_reg, predictor_next;
    logic [6:0]         step_index_reg, step_index_next;
    logic [31:0]        samples_left_reg, samples_left_next;
    logic               hnn_reg, hnn_next;
    logic [7:0]         held_reg, held_next;
    logic               lbh_reg, lbh_next;
    logic               phase_reg, phase_next;

    logic               reload;
    logic               go;
    logic               use_high;
    logic signed [15:0] eff_pred;
    logic [6:0]         eff_idx;
    logic [31:0]        eff_left;
    logic [31:0]        left_dec;
    logic               eff_hnn;
    logic [7:0]         eff_held;
    logic               eff_lbh;
    logic [3:0]         nibble;
    logic signed [15:0] adpcm_pred;
    logic [6:0]         adpcm_idx;

    asd_adpcm_unit u_adpcm (
        .predictor      (eff_pred),
        .step_index     (eff_idx),
        .nibble         (nibble),
        .predictor_out  (adpcm_pred),
        .step_index_out (adpcm_idx)
    );

    always_comb begin
        reload = item_valid && !phase_reg && item_first;
        go     = item_valid && out_ready;
        if (reload) begin
            eff_pred = cfg.start_predictor;
            eff_idx  = (cfg.start_step_index > asd_pkg::MAX_STEP_INDEX) ?
                       asd_pkg::MAX_STEP_INDEX : cfg.start_step_index;
            eff_left = cfg.sample_count;
            eff_hnn  = 1'b0;
            eff_held = 8'd0;
            eff_lbh  = 1'b0;
        end else begin
            eff_pred = predictor_reg;
            eff_idx  = step_index_reg;
            eff_left = samples_left_reg;
            eff_hnn  = hnn_reg;
            eff_held = held_reg;
            eff_lbh  = lbh_reg;
        end
        left_dec = eff_left - 32'd1;
        use_high = phase_reg || eff_hnn;
        nibble   = use_high ? item_byte[7:4] : item_byte[3:0];

        predictor_next    = predictor_reg;
        step_index_next   = step_index_reg;
        samples_left_next = samples_left_reg;
        hnn_next          = hnn_reg;
        held_next         = held_reg;
        lbh_next          = lbh_reg;
        phase_next        = phase_reg;
        consume           = 1'b0;
        emit              = 1'b0;
        result.sample      = 16'sd0;
        result.last_of_run = 1'b1;
        result.stream_done = (left_dec == 32'd0);

        if (go) begin
            predictor_next    = eff_pred;
            step_index_next   = eff_idx;
            samples_left_next = eff_left;
            hnn_next          = eff_hnn;
            held_next         = eff_held;
            lbh_next          = eff_lbh;
            if (eff_left == 32'd0) begin
                consume = 1'b1;
            end else begin
                case (cfg.codec_mode)
                    asd_pkg::MODE_S16LE: begin
                        consume = 1'b1;
                        if (!eff_lbh) begin
                            held_next = item_byte;
                            lbh_next  = 1'b1;
                        end else begin
                            lbh_next          = 1'b0;
                            emit              = 1'b1;
                            samples_left_next = left_dec;
                            result.sample     = {item_byte, eff_held};
                        end
                    end
                    asd_pkg::MODE_U8: begin
                        consume           = 1'b1;
                        emit              = 1'b1;
                        samples_left_next = left_dec;
                        result.sample     = {~item_byte[7], item_byte[6:0], 8'h00};
                    end
                    asd_pkg::MODE_MULAW: begin
                        consume           = 1'b1;
                        emit              = 1'b1;
                        samples_left_next = left_dec;
                        result.sample     = asd_pkg::mulaw_expand(item_byte);
                    end
                    default: begin
                        emit              = 1'b1;
                        samples_left_next = left_dec;
                        predictor_next    = adpcm_pred;
                        step_index_next   = adpcm_idx;
                        result.sample     = adpcm_pred;
                        if (!use_high) begin
                            hnn_next = 1'b1;
                            if (left_dec != 32'd0) begin
                                phase_next         = 1'b1;
                                result.last_of_run = 1'b0;
                            end else begin
                                consume = 1'b1;
                            end
                        end else begin
                            hnn_next   = 1'b0;
                            phase_next = 1'b0;
                            consume    = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            predictor_reg    <= 16'sd0;
            step_index_reg   <= 7'd0;
            samples_left_reg <= 32'd0;
            hnn_reg          <= 1'b0;
            held_reg         <= 8'd0;
            lbh_reg          <= 1'b0;
            phase_reg        <= 1'b0;
        end else begin
            predictor_reg    <= predictor_next;
            step_index_reg   <= step_index_next;
            samples_left_reg <= samples_left_next;
            hnn_reg          <= hnn_next;
            held_reg         <= held_next;
            lbh_reg          <= lbh_next;
            phase_reg        <= phase_next;
        end
    end

    `ASSERT_NEVER(a_index_range, aclk, aresetn, step_index_reg > asd_pkg::MAX_STEP_INDEX)
    `ASSERT_SYNC(a_phase_needs_item, aclk, aresetn, phase_reg |-> (item_valid && hnn_reg))
    `ASSERT_SYNC(a_phase_has_budget, aclk, aresetn, phase_reg |-> (samples_left_reg != 32'd0))
    `ASSERT_NEVER(a_emit_on_spent, aclk, aresetn, emit && (eff_left == 32'd0))

endmodule

[rtl/core/audio_sample_stream_decoder.sv]
// Top level: config registers, input register, decode core and output register.
// An accepted transfer is registered in the input register, its samples in the output one.
// Throughput: one byte per cycle unless the output stalls; the single shared ADPCM
// nibble unit does one nibble per cycle, so a two-sample ADPCM byte is held for both.
// Reset: synchronous active-low aresetn clears control state; config returns to defaults.
module audio_sample_stream_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] first_of_stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] sample
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // [0] stream_done
);

    asd_pkg::cfg_t    cfg_reg;
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_first_reg;
    logic             out_valid_reg;
    asd_pkg::result_t out_reg;

    logic             out_ready;
    logic             consume;
    logic             emit;
    asd_pkg::result_t result;

    assign cfg_ready     = 1'b1;
    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || consume;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.sample;
    assign m_axis_tlast  = out_reg.last_of_run;
    assign m_axis_tuser  = out_reg.stream_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.codec_mode       <= asd_pkg::MODE_S16LE;
            cfg_reg.sample_count     <= asd_pkg::SAMPLE_COUNT_RESET;
            cfg_reg.start_predictor  <= 16'sd0;
            cfg_reg.start_step_index <= 7'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                asd_pkg::REG_CODEC_MODE:      cfg_reg.codec_mode <= cfg_data[1:0];
                asd_pkg::REG_SAMPLE_COUNT:    cfg_reg.sample_count <= cfg_data;
                asd_pkg::REG_START_PREDICTOR: cfg_reg.start_predictor <= cfg_data[15:0];
                default:                      cfg_reg.start_step_index <= cfg_data[6:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg  <= s_axis_tdata;
            in_first_reg <= s_axis_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_reg <= result;
        end
    end

    asd_decode_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .item_valid (in_valid_reg),
        .item_byte  (in_byte_reg),
        .item_first (in_first_reg),
        .out_ready  (out_ready),
        .consume    (consume),
        .emit       (emit),
        .result     (result)
    );

endmodule
